// File: design/safil_pkg.sv
// Shared types, op codes, fault bit positions and state codes for the
// safety interlock lease watchdog. No dependencies.
package safil_pkg;

    // Request op codes; codes 6 and 7 behave as a protocol error
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_HELLO  = 3'd1,
        OP_LEASE  = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_DEBUG  = 3'd4,
        OP_PROTO  = 3'd5
    } t_op;

    // Fault bit positions
    localparam int FB_ESTOP    = 0;
    localparam int FB_BUMPER   = 1;
    localparam int FB_HOST     = 2;
    localparam int FB_UPSTREAM = 3;
    localparam int FB_DRIVER   = 4;
    localparam int FB_POWER    = 5;
    localparam int FB_PROTO    = 6;
    localparam int FAULT_W     = 7;

    // Reported safe state codes
    localparam logic [2:0] SS_BOOT    = 3'd0;
    localparam logic [2:0] SS_STANDBY = 3'd1;
    localparam logic [2:0] SS_RUNNING = 3'd2;
    localparam logic [2:0] SS_STOP    = 3'd3;
    localparam logic [2:0] SS_FAULT   = 3'd4;

    // Supervisor mode, one-hot
    typedef enum logic [4:0] {
        MODE_BOOT    = 5'b00001,
        MODE_STANDBY = 5'b00010,
        MODE_RUNNING = 5'b00100,
        MODE_STOP    = 5'b01000,
        MODE_FAULT   = 5'b10000
    } t_mode;

    // Request word
    typedef struct packed {
        logic [2:0]         op;
        logic               estop_closed;
        logic               bumper_closed;
        logic [31:0]        seq;
        logic [31:0]        lease_timeout;
        logic               host_alive;
        logic               upstream_valid;
        logic               drive_ok;
        logic               supply_ok;
        logic [FAULT_W-1:0] unlatch_mask;
        logic [31:0]        confirm_code;
    } t_in_word;

    // Status word
    typedef struct packed {
        logic [31:0]        reply_seq;
        logic [2:0]         safe_state;
        logic               motion_on;
        logic               estop_level;
        logic               bumper_level;
        logic [FAULT_W-1:0] live_faults;
        logic [FAULT_W-1:0] held_faults;
        logic [31:0]        uptime_ms;
        logic [31:0]        heartbeat;
        logic [31:0]        recorded_seq;
        logic [31:0]        lease_age;
        logic [31:0]        loop_count;
    } t_out_word;

    // One-hot mode to reported code
    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_BOOT:    c = SS_BOOT;
            MODE_STANDBY: c = SS_STANDBY;
            MODE_RUNNING: c = SS_RUNNING;
            MODE_STOP:    c = SS_STOP;
            MODE_FAULT:   c = SS_FAULT;
            default:      c = SS_BOOT;
        endcase
        return c;
    endfunction

endpackage

// File: design/safil_ifs.sv
// Valid/ready channel interfaces for requests, status words and the key write.
// Depends on safil_pkg.

interface safil_cmd_if;
    import safil_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface safil_rsp_if;
    import safil_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface safil_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/safety_interlock_lease_watchdog.sv
// Top level of the motion-enable safety supervisor: input register, event
// logic and status register. Depends on safil_pkg and safil_ifs.
//
//   channel   dir  word         notes
//   i_cmd     in   t_in_word    one request or tick per word
//   o_rsp     out  t_out_word   one status word per word taken
//   i_cfg     in   32-bit key   clear_key write, always ready
//
// One word per cycle sustained while o_rsp does not stall; each word passes
// through the input register, then the status register, to o_rsp. The state
// update and the status word are produced together as a word leaves the input
// register. Reset puts all state in its initial values (contacts, driver and
// power read as good) and clears the key and both valid flags. A stall on o_rsp
// holds the status word and, once the input register is full, i_cmd.
module safety_interlock_lease_watchdog
    import safil_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    safil_cmd_if.sink   i_cmd,
    safil_rsp_if.source o_rsp,
    safil_cfg_if.sink   i_cfg
);

    // pipeline registers
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;

    // supervisor state
    logic [31:0]        r_clear_key;
    logic [31:0]        r_uptime,    n_uptime;
    logic [31:0]        r_loop,      n_loop;
    logic [31:0]        r_heartbeat, n_heartbeat;
    logic [31:0]        r_last_seq,  n_last_seq;
    logic [31:0]        r_stamp,     n_stamp;
    logic [31:0]        r_age,       n_age;
    logic [31:0]        r_timeout,   n_timeout;
    logic               r_seen,      n_seen;
    logic               r_alive,     n_alive;
    logic               r_upstream,  n_upstream;
    logic               r_driver,    n_driver;
    logic               r_power,     n_power;
    logic               r_estop,     n_estop;
    logic               r_bumper,    n_bumper;
    t_mode              r_mode,      n_mode;
    logic               r_enable,    n_enable;
    logic [FAULT_W-1:0] r_fault,     n_fault;
    logic [FAULT_W-1:0] r_latched,   n_latched;
    t_out_word          n_out;

    // scratch for the event logic
    logic               pass_en;
    logic               wd_en;
    logic               eval_en;
    logic [31:0]        age;
    logic [FAULT_W-1:0] clr;
    logic [FAULT_W-1:0] f;

    // handshakes
    assign advance       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready   = !r_in_valid || advance;
    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.data    = r_out;

    // event logic on the registered word
    always_comb begin
        n_uptime    = r_uptime;
        n_loop      = r_loop;
        n_heartbeat = r_heartbeat;
        n_last_seq  = r_last_seq;
        n_stamp     = r_stamp;
        n_age       = r_age;
        n_timeout   = r_timeout;
        n_seen      = r_seen;
        n_alive     = r_alive;
        n_upstream  = r_upstream;
        n_driver    = r_driver;
        n_power     = r_power;
        n_estop     = r_estop;
        n_bumper    = r_bumper;
        n_mode      = r_mode;
        n_enable    = r_enable;
        n_fault     = r_fault;
        n_latched   = r_latched;
        pass_en     = 1'b0;
        wd_en       = 1'b0;
        eval_en     = 1'b0;
        age         = '0;
        f           = '0;

        // open contacts keep their latched bits
        clr = r_in.unlatch_mask;
        if (!r_estop) begin
            clr[FB_ESTOP] = 1'b0;
        end
        if (!r_bumper) begin
            clr[FB_BUMPER] = 1'b0;
        end

        case (t_op'(r_in.op))
            OP_TICK: begin
                n_uptime = r_uptime + 32'd1;
                pass_en  = 1'b1;
            end
            OP_HELLO: begin
                n_last_seq = r_in.seq;
                wd_en      = 1'b1;
            end
            OP_LEASE: begin
                n_seen     = 1'b1;
                n_last_seq = r_in.seq;
                n_stamp    = r_uptime;
                n_age      = '0;
                n_timeout  = r_in.lease_timeout;
                n_alive    = r_in.host_alive;
                n_upstream = r_in.upstream_valid;
                n_driver   = r_in.drive_ok;
                n_power    = r_in.supply_ok;
                eval_en    = 1'b1;
            end
            OP_CLEAR: begin
                if (r_in.confirm_code == r_clear_key) begin
                    n_latched = r_latched & ~clr;
                    wd_en     = 1'b1;
                    eval_en   = 1'b1;
                end
                n_last_seq = r_in.seq;
            end
            OP_DEBUG: begin
                pass_en    = 1'b1;
                n_last_seq = r_in.seq;
            end
            default: begin
                // protocol error, also the unused codes
                n_fault = r_fault;
                n_fault[FB_PROTO] = 1'b1;
            end
        endcase

        // safety pass: count and sample contacts
        if (pass_en) begin
            n_loop   = r_loop + 32'd1;
            n_estop  = r_in.estop_closed;
            n_bumper = r_in.bumper_closed;
            wd_en    = 1'b1;
            eval_en  = 1'b1;
        end

        // lease watchdog
        if (wd_en && r_seen && (r_timeout != 32'd0)) begin
            age   = n_uptime - r_stamp;
            n_age = age;
            if (age > r_timeout) begin
                n_alive = 1'b0;
            end
        end

        // fault evaluation
        if (eval_en) begin
            f[FB_ESTOP]    = !n_estop;
            f[FB_BUMPER]   = !n_bumper;
            f[FB_HOST]     = !n_alive;
            f[FB_UPSTREAM] = !n_upstream;
            f[FB_DRIVER]   = !n_driver;
            f[FB_POWER]    = !n_power;
            n_fault        = f;
            n_latched[FB_ESTOP]  = n_latched[FB_ESTOP] | f[FB_ESTOP];
            n_latched[FB_BUMPER] = n_latched[FB_BUMPER] | f[FB_BUMPER];
            n_enable = n_estop && n_bumper && (n_latched == '0) && n_alive
                       && n_upstream && n_driver && n_power;
            if (n_latched != '0) begin
                n_mode = MODE_FAULT;
            end else if (n_enable) begin
                n_mode = MODE_RUNNING;
            end else if (f != '0) begin
                n_mode = MODE_STOP;
            end else begin
                n_mode = MODE_STANDBY;
            end
        end

        if (t_op'(r_in.op) != OP_TICK) begin
            n_heartbeat = r_heartbeat + 32'd1;
        end

        // status word
        n_out.reply_seq    = (t_op'(r_in.op) == OP_TICK) ? 32'd0 : r_in.seq;
        n_out.safe_state   = mode_code(n_mode);
        n_out.motion_on    = n_enable;
        n_out.estop_level  = n_estop;
        n_out.bumper_level = n_bumper;
        n_out.live_faults  = n_fault;
        n_out.held_faults  = n_latched;
        n_out.uptime_ms    = n_uptime;
        n_out.heartbeat    = n_heartbeat;
        n_out.recorded_seq = n_last_seq;
        n_out.lease_age    = n_age;
        n_out.loop_count   = n_loop;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
    end

    // status register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // confirm key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_key <= '0;
        end else if (i_cfg.valid) begin
            r_clear_key <= i_cfg.data;
        end
    end

    // supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uptime    <= '0;
            r_loop      <= '0;
            r_heartbeat <= '0;
            r_last_seq  <= '0;
            r_stamp     <= '0;
            r_age       <= '0;
            r_timeout   <= '0;
            r_seen      <= 1'b0;
            r_alive     <= 1'b0;
            r_upstream  <= 1'b0;
            r_driver    <= 1'b1;
            r_power     <= 1'b1;
            r_estop     <= 1'b1;
            r_bumper    <= 1'b1;
            r_mode      <= MODE_BOOT;
            r_enable    <= 1'b0;
            r_fault     <= '0;
            r_latched   <= '0;
        end else if (advance) begin
            r_uptime    <= n_uptime;
            r_loop      <= n_loop;
            r_heartbeat <= n_heartbeat;
            r_last_seq  <= n_last_seq;
            r_stamp     <= n_stamp;
            r_age       <= n_age;
            r_timeout   <= n_timeout;
            r_seen      <= n_seen;
            r_alive     <= n_alive;
            r_upstream  <= n_upstream;
            r_driver    <= n_driver;
            r_power     <= n_power;
            r_estop     <= n_estop;
            r_bumper    <= n_bumper;
            r_mode      <= n_mode;
            r_enable    <= n_enable;
            r_fault     <= n_fault;
            r_latched   <= n_latched;
        end
    end

endmodule

// File: design/safil_checker.sv
// Port-level checks on the status channel of the safety supervisor, and the
// bind that attaches them to the top level. Depends on safil_pkg.
module safil_checker
    import safil_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input t_out_word rsp_data
);

    // a stalled status word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("status word changed while stalled");

    // motion only with contacts closed, no hardware fault and nothing latched
    a_motion_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.motion_on |->
            rsp_data.estop_level && rsp_data.bumper_level &&
            (rsp_data.live_faults[FB_POWER:FB_ESTOP] == '0) &&
            (rsp_data.held_faults == '0) && (rsp_data.safe_state == SS_RUNNING))
        else $error("motion enabled with a fault present");

    // latched faults and the fault state go together
    a_fault_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> ((rsp_data.held_faults != '0) == (rsp_data.safe_state == SS_FAULT)))
        else $error("fault state disagrees with latched bits");

    // only contact faults are ever latched
    a_latch_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_data.held_faults[FAULT_W-1:FB_HOST] == '0))
        else $error("non-contact fault latched");

endmodule

bind safety_interlock_lease_watchdog safil_checker u_safil_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp_data  (o_rsp.data)
);
